// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define SGPG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// plain condition checked on every rising edge outside reset
`define SGPG_ASSERT_COND(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("condition failed");

`endif

// File: hdl/sgpg_pkg.sv
// shared constants, font table, command types and pixel helpers
`timescale 1ns / 1ps

package sgpg_pkg;

  localparam int MAX_SCALE   = 4;
  localparam int GLYPH_SIZE  = 8;
  localparam int FIRST_CODE  = 32;
  localparam int LAST_CODE   = 90;
  localparam int NUM_GLYPHS  = LAST_CODE - FIRST_CODE + 1;
  localparam int PIX_W       = 16;
  localparam int MAX_PIX     = GLYPH_SIZE * MAX_SCALE;
  localparam int LINE_W      = MAX_PIX * PIX_W;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 520;
  localparam int COUNT_W     = 6;
  localparam int GLYPH_IDX_W = 6;
  localparam int SCALE_W     = 3;

  typedef struct packed {
    logic load;
    logic emit;
  } sgpg_cmd_t;

  typedef struct packed {
    logic last_line;
  } sgpg_sts_t;

  // row 0 in the top byte
  localparam logic [63:0] FONT_ROM [NUM_GLYPHS] = '{
    64'h0000000000000000, 64'h183C3C1818001800, 64'h3636000000000000,
    64'h36367F367F363600, 64'h0C3E031E301F0C00, 64'h006333180C666300,
    64'h1C361C6E3B336E00, 64'h0606030000000000, 64'h180C0606060C1800,
    64'h060C1818180C0600, 64'h00663CFF3C660000, 64'h000C0C3F0C0C0000,
    64'h00000000000C0C06, 64'h0000003F00000000, 64'h00000000000C0C00,
    64'h6030180C06030100, 64'h3E63737B6F673E00, 64'h0C0E0C0C0C0C3F00,
    64'h1E33301C06333F00, 64'h1E33301C30331E00, 64'h383C36337F307800,
    64'h3F031F3030331E00, 64'h1C06031F33331E00, 64'h3F3330180C0C0C00,
    64'h1E33331E33331E00, 64'h1E33333E30180E00, 64'h000C0C00000C0C00,
    64'h000C0C00000C0C06, 64'h180C0603060C1800, 64'h00003F00003F0000,
    64'h060C1830180C0600, 64'h1E3330180C000C00, 64'h3E637B7B7B031E00,
    64'h0C1E33333F333300, 64'h3F66663E66663F00, 64'h3C66030303663C00,
    64'h1F36666666361F00, 64'h7F46161E16467F00, 64'h7F46161E16060F00,
    64'h3C66030373667C00, 64'h3333333F33333300, 64'h1E0C0C0C0C0C1E00,
    64'h7830303033331E00, 64'h6766361E36666700, 64'h0F06060646667F00,
    64'h63777F7F6B636300, 64'h63676F7B73636300, 64'h1C36636363361C00,
    64'h3F66663E06060F00, 64'h1E3333333B1E3800, 64'h3F66663E36666700,
    64'h1E33070E38331E00, 64'h3F2D0C0C0C0C1E00, 64'h3333333333333F00,
    64'h33333333331E0C00, 64'h6363636B7F776300, 64'h6363361C1C366300,
    64'h3333331E0C0C1E00, 64'h7F6331184C667F00
  };

  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
    logic [7:0] idx;
    begin
      if (code < 8'(FIRST_CODE) || code > 8'(LAST_CODE)) begin
        idx = 8'd0;
      end else begin
        idx = code - 8'(FIRST_CODE);
      end
      glyph_index = idx[GLYPH_IDX_W-1:0];
    end
  endfunction

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [7:0] sc);
    logic [SCALE_W-1:0] res;
    begin
      if (sc == 8'd0) begin
        res = SCALE_W'(1);
      end else if (sc > 8'(MAX_SCALE)) begin
        res = SCALE_W'(MAX_SCALE);
      end else begin
        res = sc[SCALE_W-1:0];
      end
      clamp_scale = res;
    end
  endfunction

  // set bit per output pixel of one magnified row
  function automatic logic [MAX_PIX-1:0] glyph_expand(input logic [7:0] bits,
                                                      input logic [SCALE_W-1:0] sc);
    logic [MAX_PIX-1:0] m;
    logic [2:0]         col;
    begin
      m = '0;
      for (int px = 0; px < MAX_PIX; px++) begin
        case (sc)
          3'd1:    col = 3'(px);
          3'd2:    col = 3'(px / 2);
          3'd3:    col = 3'(px / 3);
          default: col = 3'(px / 4);
        endcase
        m[px] = bits[col];
      end
      glyph_expand = m;
    end
  endfunction

endpackage

// File: hdl/sgpg_ctrl.sv
// controller: accepts characters and paces line beats into the output register
`timescale 1ns / 1ps

module sgpg_ctrl
  import sgpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output sgpg_cmd_t cmd,
  input  sgpg_sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_line) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/sgpg_datapath.sv
// datapath: character registers, row counters, line expansion and output register
`timescale 1ns / 1ps

module sgpg_datapath
  import sgpg_pkg::*;
(
  input  logic                  clk,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  sgpg_cmd_t             cmd,
  output sgpg_sts_t             sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [GLYPH_IDX_W-1:0] glyph_r;
  logic [PIX_W-1:0]       fg_r;
  logic [PIX_W-1:0]       bg_r;
  logic [SCALE_W-1:0]     scale_r;
  logic [2:0]             row_r, row_nxt;
  logic [1:0]             sub_r, sub_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic [COUNT_W-1:0]     count_r;
  logic                   last_r;

  logic [63:0]            glyph_rows;
  logic [7:0]             row_bits;
  logic [MAX_PIX-1:0]     on_mask;
  logic [COUNT_W-1:0]     count;
  logic                   sub_end;

  assign glyph_rows = FONT_ROM[glyph_r];
  assign row_bits   = glyph_rows[{~row_r, 3'b000} +: 8];
  assign on_mask    = glyph_expand(row_bits, scale_r);
  assign count      = {scale_r, 3'b000};
  assign sub_end    = ({1'b0, sub_r} == scale_r - SCALE_W'(1));
  assign sts.last_line = sub_end && (row_r == 3'd7);

  always_comb begin
    for (int px = 0; px < MAX_PIX; px++) begin
      if (COUNT_W'(px) < count) begin
        line_nxt[px*PIX_W +: PIX_W] = on_mask[px] ? fg_r : bg_r;
      end else begin
        line_nxt[px*PIX_W +: PIX_W] = '0;
      end
    end
  end

  always_comb begin
    row_nxt = row_r;
    sub_nxt = sub_r + 2'd1;
    if (sub_end) begin
      sub_nxt = 2'd0;
      row_nxt = row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= glyph_index(in_tdata[7:0]);
      fg_r    <= in_tdata[23:8];
      bg_r    <= in_tdata[39:24];
      scale_r <= clamp_scale(in_tdata[47:40]);
      row_r   <= 3'd0;
      sub_r   <= 2'd0;
    end else if (cmd.emit) begin
      row_r   <= row_nxt;
      sub_r   <= sub_nxt;
    end
    if (cmd.emit) begin
      line_r  <= line_nxt;
      count_r <= count;
      last_r  <= sts.last_line;
    end
  end

  assign out_tdata = {{(OUT_DATA_W - LINE_W - COUNT_W){1'b0}}, count_r, line_r};
  assign out_tlast = last_r;

endmodule

// File: hdl/scaled_glyph_pixel_generator.sv
// top level of the scaled glyph pixel generator
// channel  dir  fields
// in_      in   char_code, fg_color, back_colour, scale
// out_     out  pixel words 0..7, pixel_count; last_line as tlast
// one beat in, 8*scale line beats out (scale clamped to 1..4)
// the first line is registered once the controller has loaded the accepted character, then one line
// per cycle while out_tready is high
// the next character is taken as soon as its predecessor's last line is registered
// a stall on out_tready holds the output register and the row counters
// reset (rst_n low, synchronous) empties the output register and idles the controller
`timescale 1ns / 1ps

module scaled_glyph_pixel_generator
  import sgpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_code, fg_color, back_colour, scale
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixels_0_to_3 .. pixels_28_to_31, pixel_count
  output logic                  out_tlast
);

  sgpg_cmd_t cmd;
  sgpg_sts_t sts;

  sgpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sgpg_datapath u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// File: hdl/sgpg_checker.sv
// port-level checker for the scaled glyph pixel generator
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgpg_checker
  import sgpg_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [COUNT_W-1:0] cnt;
  logic               cnt_ok;
  assign cnt    = out_tdata[LINE_W +: COUNT_W];
  assign cnt_ok = (cnt == 6'd8) || (cnt == 6'd16) || (cnt == 6'd24) || (cnt == 6'd32);

  `SGPG_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `SGPG_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `SGPG_ASSERT(a_no_accept_mid_cell, clk, rst_n, out_tvalid && !out_tlast |-> !in_tready)
  `SGPG_ASSERT_COND(a_count_legal, clk, rst_n, !out_tvalid || cnt_ok)

endmodule

bind scaled_glyph_pixel_generator sgpg_checker u_sgpg_checker (.*);
